>>> hw/rtl/dix_pkg.sv
// dix_pkg: types, codes and constants of the DER integer extractor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dix_pkg;

	localparam int LENGTH_BITS_DEF = 32;
	localparam int FIFO_DEPTH      = 4;
	localparam int FIFO_PTR_W      = 2;
	localparam int FIFO_CNT_W      = 3;

	localparam logic [3:0] ELEM_LIMIT_RST = 4'd9;

	localparam logic [7:0] TAG_SEQUENCE = 8'h30;
	localparam logic [7:0] TAG_INTEGER  = 8'h02;
	localparam logic [7:0] LEN_LONG     = 8'h80;
	localparam logic [7:0] LEN_MASK     = 8'h7F;

	localparam logic [1:0] KIND_CONTENT = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	typedef enum logic [2:0] {
		PH_SEQ_TAG,
		PH_SEQ_LEN,
		PH_SEQ_SKIP,
		PH_SCAN,
		PH_INT_LEN,
		PH_INT_LENBYTES,
		PH_CONTENT
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value_byte;
		logic [3:0] element_index;
		logic       first_of_element;
		logic       last_of_element;
		logic [3:0] element_count;
		logic       last_result;
	} out_item_t;

	// up to two results produced by one input byte
	typedef struct packed {
		logic [1:0] n;
		out_item_t  r0;
		out_item_t  r1;
	} push_t;

endpackage

>>> hw/rtl/dix_parser.sv
// dix_parser: DER walk state and the per-byte step logic.
// Depends on dix_pkg.
`timescale 1ns / 1ps

module dix_parser
	import dix_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  in_item_t   item,
	input  logic [3:0] elem_limit,
	output push_t      push
);

	phase_t                 phase_q, phase_n;
	logic [6:0]             skip_q, skip_n;
	logic [6:0]             lbr_q, lbr_n;
	logic [LENGTH_BITS-1:0] cr_q, cr_n;
	logic [3:0]             found_q, found_n;
	logic                   first_q, first_n;

	logic       consumed;
	logic       len_done;
	logic       has_res;
	logic [3:0] count_after;
	out_item_t  res;
	out_item_t  summary;
	logic [7:0] b;

	assign b = item.data_byte;

	// next state
	always_comb begin
		phase_n  = phase_q;
		skip_n   = skip_q;
		lbr_n    = lbr_q;
		cr_n     = cr_q;
		found_n  = found_q;
		first_n  = first_q;
		consumed = 1'b0;
		len_done = 1'b0;
		has_res  = 1'b0;

		// sequence header
		case (phase_q)
			PH_SEQ_TAG: begin
				if (b == TAG_SEQUENCE) begin
					phase_n  = PH_SEQ_LEN;
					consumed = 1'b1;
				end else begin
					phase_n = PH_SCAN;
				end
			end
			PH_SEQ_LEN: begin
				consumed = 1'b1;
				phase_n  = PH_SCAN;
				if ((b & LEN_LONG) != 8'h00) begin
					skip_n = b[6:0];
					if (b[6:0] != 7'd0)
						phase_n = PH_SEQ_SKIP;
				end
			end
			PH_SEQ_SKIP: begin
				consumed = 1'b1;
				skip_n   = skip_q - 7'd1;
				if (skip_n == 7'd0)
					phase_n = PH_SCAN;
			end
			default: ;
		endcase

		if (!consumed) begin
			case (phase_n)
				PH_SCAN: begin
					if (found_q < elem_limit && b == TAG_INTEGER)
						phase_n = PH_INT_LEN;
				end
				PH_INT_LEN: begin
					if ((b & LEN_LONG) != 8'h00) begin
						cr_n  = '0;
						lbr_n = 7'(b & LEN_MASK);
						if (lbr_n == 7'd0)
							len_done = 1'b1;
						else
							phase_n = PH_INT_LENBYTES;
					end else begin
						cr_n     = LENGTH_BITS'(b);
						len_done = 1'b1;
					end
				end
				PH_INT_LENBYTES: begin
					// high length bits fall out of the register
					cr_n  = LENGTH_BITS'({cr_q, b});
					lbr_n = lbr_q - 7'd1;
					if (lbr_n == 7'd0)
						len_done = 1'b1;
				end
				PH_CONTENT: begin
					has_res = 1'b1;
					first_n = 1'b0;
					cr_n    = cr_q - LENGTH_BITS'(1);
					if (cr_n == '0)
						phase_n = PH_SCAN;
				end
				default: phase_n = PH_SCAN;
			endcase
		end

		if (len_done) begin
			found_n = found_q + 4'd1;
			if (cr_n == '0) begin
				has_res = 1'b1;
				phase_n = PH_SCAN;
			end else begin
				first_n = 1'b1;
				phase_n = PH_CONTENT;
			end
		end

		// end of stream: back to reset state
		if (item.end_of_data) begin
			phase_n = PH_SEQ_TAG;
			skip_n  = '0;
			lbr_n   = '0;
			cr_n    = '0;
			found_n = '0;
			first_n = 1'b0;
		end
	end

	// results
	always_comb begin
		count_after = len_done ? found_q + 4'd1 : found_q;

		res = '0;
		if (len_done) begin
			res.kind            = KIND_EMPTY;
			res.element_index   = found_q;
			res.last_of_element = 1'b1;
			res.element_count   = count_after;
		end else begin
			res.kind             = KIND_CONTENT;
			res.value_byte       = b;
			res.element_index    = found_q - 4'd1;
			res.first_of_element = first_q;
			res.last_of_element  = (cr_q == LENGTH_BITS'(1));
			res.element_count    = found_q;
		end

		summary               = '0;
		summary.kind          = KIND_SUMMARY;
		summary.element_count = count_after;
		summary.last_result   = 1'b1;

		push = '0;
		if (has_res && item.end_of_data) begin
			push.n  = 2'd2;
			push.r0 = res;
			push.r1 = summary;
		end else if (has_res) begin
			push.n              = 2'd1;
			push.r0             = res;
			push.r0.last_result = 1'b1;
		end else if (item.end_of_data) begin
			push.n  = 2'd1;
			push.r0 = summary;
		end
		if (!step)
			push.n = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEQ_TAG;
			skip_q  <= '0;
			lbr_q   <= '0;
			cr_q    <= '0;
			found_q <= '0;
			first_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			skip_q  <= skip_n;
			lbr_q   <= lbr_n;
			cr_q    <= cr_n;
			found_q <= found_n;
			first_q <= first_n;
		end
	end

	a_content_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CONTENT |-> cr_q != '0)
		else $error("content phase with zero length left");

	a_two_needs_end: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> item.end_of_data && push.r1.kind == KIND_SUMMARY)
		else $error("second result without end of stream");

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.end_of_data |=> phase_q == PH_SEQ_TAG && found_q == 4'd0)
		else $error("state not cleared after final byte");

endmodule

>>> hw/rtl/dix_out_fifo.sv
// dix_out_fifo: four-entry result queue, up to two pushes and one pop a cycle.
// Depends on dix_pkg.
`timescale 1ns / 1ps

module dix_out_fifo
	import dix_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  push_t     push,
	output logic      space,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	out_item_t             mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q, rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  pop;

	assign out_valid = (cnt_q != '0);
	assign out_data  = mem[rd_q];
	assign pop       = out_valid && out_ready;
	// room for the worst case of two results
	assign space     = (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem[wr_q] <= push.r0;
		if (push.n == 2'd2)
			mem[wr_q + FIFO_PTR_W'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + FIFO_PTR_W'(push.n);
			rd_q  <= rd_q + FIFO_PTR_W'(pop);
			cnt_q <= cnt_q + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2))
		else $error("result queue overflow");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("result count out of range");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push.n == 2'd0 |=> cnt_q == $past(cnt_q) - FIFO_CNT_W'(1))
		else $error("pop did not lower count");

endmodule

>>> hw/rtl/der_integer_extractor_top.sv
// der_integer_extractor_top: input register, config register, parser, result queue.
// Depends on dix_pkg, dix_parser, dix_out_fifo.
//
//  channel | signals                     | payload
//  in      | in_valid / in_ready         | in_data  (in_item_t)
//  out     | out_valid / out_ready       | out_data (out_item_t)
//  cfg     | cfg_valid / cfg_ready       | cfg_data (element limit, 4 bits)
//
// One byte a cycle enters while the result queue has room; a byte yields zero,
// one or two results, drained one a cycle while out_ready is high; two-result
// bytes are the final byte of a stream that also yields an element result.
// An input byte is held in the input register, its results in the result queue.
// in_ready depends only on registered state (input register valid and queue fill), not on out_ready.
// arst_n clears walk state and queue; the element limit resets to 9.
`timescale 1ns / 1ps

module der_integer_extractor_top
	import dix_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_data
);

	in_item_t   item_s1;
	logic       valid_s1;
	logic [3:0] elem_limit_q;
	logic       space;
	logic       step;
	push_t      push;

	assign cfg_ready = 1'b1;
	assign step      = valid_s1 && space;
	assign in_ready  = !valid_s1 || space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			elem_limit_q <= ELEM_LIMIT_RST;
		else if (cfg_valid && cfg_ready)
			elem_limit_q <= cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
	end

	dix_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.elem_limit(elem_limit_q),
		.push      (push)
	);

	dix_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space    (space),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule
